@@ rtl/intel_hex_record_parser_unit_defines.svh @@
// Assertion macros shared by the hex record parser RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define IHEX_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define IHEX_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ihex_pkg.sv @@
// Types, codes and constants for the hex record parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ihex_pkg;

  // Parser phases within one line
  typedef enum logic [2:0] {
    PH_START,
    PH_LEN,
    PH_ADDR,
    PH_TYPE,
    PH_DATA,
    PH_CKSUM,
    PH_TRAIL,
    PH_HALT
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_REC_OK,
    KIND_EOF,
    KIND_ERROR
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_START,
    ERR_HDR_HEX,
    ERR_DATA_HEX,
    ERR_CKSUM_HEX,
    ERR_MISMATCH,
    ERR_BAD_TYPE,
    ERR_EMPTY_REC
  } err_t;

  // Characters and record codes
  localparam logic [7:0]  CHAR_COLON    = 8'h3A;
  localparam logic [7:0]  CHAR_LF       = 8'h0A;
  localparam logic [7:0]  CHAR_0        = 8'h30;
  localparam logic [7:0]  CHAR_9        = 8'h39;
  localparam logic [7:0]  CHAR_UA       = 8'h41;
  localparam logic [7:0]  CHAR_UF       = 8'h46;
  localparam logic [7:0]  CHAR_LA       = 8'h61;
  localparam logic [7:0]  CHAR_LF_HEX   = 8'h66;
  localparam logic [7:0]  REC_TYPE_DATA = 8'h00;
  localparam logic [7:0]  REC_TYPE_EOF  = 8'h01;
  localparam logic [15:0] LINE_MAX      = 16'hFFFF;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_length;
    err_t        error_code;
    logic [15:0] line_count;
  } ihex_item_t;

  // Result request from the parser core to the output buffer
  typedef struct packed {
    logic       valid;
    ihex_item_t item;
  } ihex_res_t;

endpackage

@@ rtl/ihex_hexdec.sv @@
// Hex digit decoder: ASCII character to nibble, either letter case.
// Depends on ihex_pkg for the character constants.
`timescale 1ns / 1ps

module ihex_hexdec (
  input  logic [7:0] ch,
  output logic       is_hex,
  output logic [3:0] nib
);
  import ihex_pkg::*;

  logic [7:0] diff;

  // Classify and convert the character
  always_comb begin
    diff   = '0;
    is_hex = 1'b0;
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      diff   = ch - CHAR_0;
      is_hex = 1'b1;
    end else if (ch >= CHAR_LA && ch <= CHAR_LF_HEX) begin
      diff   = ch - CHAR_LA + 8'd10;
      is_hex = 1'b1;
    end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
      diff   = ch - CHAR_UA + 8'd10;
      is_hex = 1'b1;
    end
    nib = diff[3:0];
  end

endmodule

@@ rtl/ihex_core.sv @@
// Parser core: line state, field assembly, checksum and result formation.
// Depends on ihex_pkg, ihex_hexdec and the assertion macro header.
`timescale 1ns / 1ps
`include "intel_hex_record_parser_unit_defines.svh"

module ihex_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  logic [7:0]        in_char,
  output ihex_pkg::ihex_res_t res
);
  import ihex_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [1:0]  fdi_r, fdi_nxt;
  logic [7:0]  rec_length_r, rec_length_nxt;
  logic [15:0] rec_address_r, rec_address_nxt;
  logic [7:0]  byte_counter_r, byte_counter_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] lines_seen_r, lines_seen_nxt;

  logic        is_hex;
  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  sum_b;
  logic [15:0] addr_shift;
  logic        fail;
  err_t        fail_code;
  logic        emit;
  kind_t       emit_kind;
  logic [15:0] emit_addr;
  logic [7:0]  emit_data;

  ihex_hexdec u_hexdec (
    .ch     (in_char),
    .is_hex (is_hex),
    .nib    (nib)
  );

  assign byte_val   = {high_nibble_r, nib};
  assign sum_b      = running_sum_r + byte_val;
  assign addr_shift = {rec_address_r[11:0], nib};

  // Hold state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      high_nibble_r  <= '0;
      fdi_r          <= '0;
      rec_length_r   <= '0;
      rec_address_r  <= '0;
      byte_counter_r <= '0;
      running_sum_r  <= '0;
      lines_seen_r   <= '0;
    end else begin
      phase_r        <= phase_nxt;
      high_nibble_r  <= high_nibble_nxt;
      fdi_r          <= fdi_nxt;
      rec_length_r   <= rec_length_nxt;
      rec_address_r  <= rec_address_nxt;
      byte_counter_r <= byte_counter_nxt;
      running_sum_r  <= running_sum_nxt;
      lines_seen_r   <= lines_seen_nxt;
    end
  end

  // Advance the parser on each accepted character
  always_comb begin
    phase_nxt        = phase_r;
    high_nibble_nxt  = high_nibble_r;
    fdi_nxt          = fdi_r;
    rec_length_nxt   = rec_length_r;
    rec_address_nxt  = rec_address_r;
    byte_counter_nxt = byte_counter_r;
    running_sum_nxt  = running_sum_r;
    lines_seen_nxt   = lines_seen_r;
    fail             = 1'b0;
    fail_code        = ERR_NONE;
    emit             = 1'b0;
    emit_kind        = KIND_DATA;
    emit_addr        = '0;
    emit_data        = '0;

    if (in_acc) begin
      unique case (phase_r)
        PH_HALT: begin
          phase_nxt = PH_HALT;
        end
        PH_TRAIL: begin
          if (in_char == CHAR_LF) begin
            phase_nxt = PH_START;
          end
        end
        PH_START: begin
          if (lines_seen_r != LINE_MAX) begin
            lines_seen_nxt = lines_seen_r + 16'd1;
          end
          rec_length_nxt   = '0;
          rec_address_nxt  = '0;
          byte_counter_nxt = '0;
          running_sum_nxt  = '0;
          fdi_nxt          = '0;
          high_nibble_nxt  = '0;
          if (in_char != CHAR_COLON) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_START;
          end else begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CKSUM: begin
          if (!is_hex) begin
            // Invalid digit: code follows the field it falls in
            fail = 1'b1;
            if (phase_r == PH_DATA) begin
              fail_code = ERR_DATA_HEX;
            end else if (phase_r == PH_CKSUM) begin
              fail_code = ERR_CKSUM_HEX;
            end else begin
              fail_code = ERR_HDR_HEX;
            end
          end else if (phase_r == PH_ADDR) begin
            // Shift in address digits, add each completed byte to the sum
            rec_address_nxt = addr_shift;
            if (fdi_r[0]) begin
              running_sum_nxt = running_sum_r + addr_shift[7:0];
            end
            if (fdi_r == 2'd3) begin
              fdi_nxt   = '0;
              phase_nxt = PH_TYPE;
            end else begin
              fdi_nxt = fdi_r + 2'd1;
            end
          end else if (fdi_r == 2'd0) begin
            high_nibble_nxt = nib;
            fdi_nxt         = 2'd1;
          end else begin
            // Second digit completes a byte
            fdi_nxt         = '0;
            running_sum_nxt = sum_b;
            case (phase_r)
              PH_LEN: begin
                rec_length_nxt = byte_val;
                phase_nxt      = PH_ADDR;
              end
              PH_TYPE: begin
                if (byte_val == REC_TYPE_EOF) begin
                  phase_nxt = PH_TRAIL;
                  emit      = 1'b1;
                  emit_kind = KIND_EOF;
                  emit_addr = rec_address_r;
                end else if (byte_val != REC_TYPE_DATA) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_TYPE;
                end else if (rec_length_r != '0) begin
                  phase_nxt = PH_DATA;
                end else begin
                  phase_nxt = PH_CKSUM;
                end
              end
              PH_DATA: begin
                byte_counter_nxt = byte_counter_r + 8'd1;
                if (byte_counter_nxt == rec_length_r) begin
                  phase_nxt = PH_CKSUM;
                end
                emit      = 1'b1;
                emit_kind = KIND_DATA;
                emit_addr = rec_address_r + {8'd0, byte_counter_r};
                emit_data = byte_val;
              end
              PH_CKSUM: begin
                if (sum_b != '0) begin
                  fail      = 1'b1;
                  fail_code = ERR_MISMATCH;
                end else if (rec_length_r == '0) begin
                  fail      = 1'b1;
                  fail_code = ERR_EMPTY_REC;
                end else begin
                  phase_nxt = PH_TRAIL;
                  emit      = 1'b1;
                  emit_kind = KIND_REC_OK;
                  emit_addr = rec_address_r;
                end
              end
              default: begin
                phase_nxt = PH_HALT;
              end
            endcase
          end
        end
      endcase
    end

    // Any error stops the parser
    if (fail) begin
      phase_nxt = PH_HALT;
    end

    // Form the result request
    res.valid              = fail | emit;
    res.item.kind          = fail ? KIND_ERROR : emit_kind;
    res.item.address       = fail ? 16'd0 : emit_addr;
    res.item.data_byte     = fail ? 8'd0 : emit_data;
    res.item.record_length = rec_length_nxt;
    res.item.error_code    = fail_code;
    res.item.line_count    = lines_seen_nxt;
  end

  `IHEX_ASSERT_NXT(a_halt_sticks, clk, rst_n, phase_r == PH_HALT, phase_r == PH_HALT, "parser left halt without reset")
  `IHEX_ASSERT_IMP(a_err_halts, clk, rst_n, res.valid && res.item.kind == KIND_ERROR, phase_nxt == PH_HALT, "error result without halt")
  `IHEX_ASSERT_IMP(a_code_matches, clk, rst_n, res.valid, (res.item.kind == KIND_ERROR) == (res.item.error_code != ERR_NONE), "error code disagrees with kind")
  `IHEX_ASSERT_IMP(a_res_on_accept, clk, rst_n, res.valid, in_acc && phase_r != PH_HALT && phase_r != PH_TRAIL, "result without an accepted character")

endmodule

@@ rtl/ihex_outbuf.sv @@
// Two-entry output buffer: result register plus skid register.
// Depends on ihex_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "intel_hex_record_parser_unit_defines.svh"

module ihex_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ihex_pkg::ihex_res_t  res,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihex_pkg::ihex_item_t out_item
);
  import ihex_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  ihex_item_t out_item_r, out_item_nxt;
  ihex_item_t skid_item_r, skid_item_nxt;
  logic       pop;

  assign pop       = out_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Hold valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  // Steer a new request to the output or the skid register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || pop) begin
        out_item_nxt  = res.item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_item_nxt  = res.item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  `IHEX_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid entry with empty output register")
  `IHEX_ASSERT_IMP(a_no_push_full, clk, rst_n, skid_valid_r, !res.valid, "request arrived while buffer full")
  `IHEX_ASSERT_NXT(a_skid_moves_up, clk, rst_n, skid_valid_r && pop, out_valid_r && !skid_valid_r, "skid entry not moved after pop")
  `IHEX_ASSERT_NXT(a_skid_holds, clk, rst_n, skid_valid_r && out_stall, skid_valid_r && $stable(skid_item_r), "skid entry lost while stalled")

endmodule

@@ rtl/intel_hex_record_parser_unit.sv @@
// A result for an accepted character is registered in the result buffer before it reaches the out_ ports.
// Throughput: one character per cycle while in_stall is low; a character gives at most one result.
// The two-entry result buffer raises in_stall only once it holds two unread results.
// Reset (rst_n low, synchronous) returns the parser to line start, clears the
// line count and empties the result buffer; no clearing pass follows.
`timescale 1ns / 1ps

module intel_hex_record_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_record_length,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_line_count
);
  import ihex_pkg::*;

  logic       in_acc;
  logic       buf_full;
  ihex_res_t  res;
  ihex_item_t item;

  // Accept a character whenever the buffer has room
  assign in_stall = buf_full;
  assign in_acc   = in_valid & ~buf_full;

  ihex_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_char (in_char),
    .res     (res)
  );

  ihex_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (item)
  );

  // Unpack the result request onto the ports
  assign out_kind          = item.kind;
  assign out_address       = item.address;
  assign out_data_byte     = item.data_byte;
  assign out_record_length = item.record_length;
  assign out_error_code    = item.error_code;
  assign out_line_count    = item.line_count;

endmodule
